[hdl/spq_pkg.sv]
package spq_pkg;

	// Queue geometry
	localparam int CAPACITY   = 16;
	localparam int PRIO_BITS  = 16;
	localparam int VALUE_BITS = 32;
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	// Action codes carried on the input tuser
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Value reported for front and back of an empty queue
	localparam logic [VALUE_BITS-1:0] INT_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [PRIO_BITS-1:0]  prio;
	} entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

endpackage

[hdl/spq_cell.sv]
module spq_cell
	import spq_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  entry_t     new_entry,
	input  entry_t     prev_entry,
	input  logic       prev_keep,
	input  entry_t     next_entry,
	input  logic       occ,
	output entry_t     entry,
	output entry_t     entry_nxt,
	output logic       keep
);

	entry_t entry_q;

	assign entry = entry_q;

	// Hold this slot on a push when it ranks at or above the new entry
	assign keep = occ && (entry_q.prio >= new_entry.prio);

	// Insert, shift back on push; shift forward on pop
	always_comb begin
		entry_nxt = entry_q;
		if (ctrl.push) begin
			if (keep)
				entry_nxt = entry_q;
			else if (prev_keep)
				entry_nxt = new_entry;
			else
				entry_nxt = prev_entry;
		end else if (ctrl.pop) begin
			entry_nxt = next_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_nxt;
	end

endmodule

[hdl/sorted_priority_queue.sv]
// Output: a result appears on the master side in the cycle after its item is taken.
// Throughput: one push or pop per cycle while the master side takes every result;
// every slot cell compares and shifts in parallel, and a result that waits in the
// output register holds off the next item until it drains.
// Reset: arst_n clears the entry count and the output valid; slot contents are
// left as they are and only occupied slots are ever read.
module sorted_priority_queue
	import spq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [47:0]  s_axis_tdata,  // item_value[31:0], item_priority[47:32]
	input  logic [0:0]   s_axis_tuser,  // action[0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata   // popped_value[31:0], front_value[63:32],
	                                    // back_value[95:64], entry_count[100:96],
	                                    // status[102:101], zero pad[103]
);

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_nxt;
	logic [VALUE_BITS-1:0] back_q;
	logic [VALUE_BITS-1:0] back_nxt;

	logic                  out_valid_q;
	logic [31:0]           out_popped_q;
	logic [31:0]           out_front_q;
	logic [31:0]           out_back_q;
	logic [4:0]            out_count_q;
	logic [1:0]            out_status_q;

	logic                  accept;
	logic                  is_pop;
	logic                  do_push;
	logic                  do_pop;
	logic                  at_end;
	logic [1:0]            status;
	cell_ctrl_t            ctrl;
	entry_t                new_entry;

	entry_t                cell_entry [CAPACITY];
	entry_t                cell_nxt   [CAPACITY];
	logic [CAPACITY-1:0]   cell_keep;
	logic [CAPACITY-1:0]   cell_occ;

	// Take an item whenever the result register is free or draining
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_pop        = (s_axis_tuser[0] == ACT_POP);

	assign new_entry.value = s_axis_tdata[31:0];
	assign new_entry.prio  = s_axis_tdata[32 +: PRIO_BITS];

	assign do_push  = accept && !is_pop && (count_q < CNT_W'(CAPACITY));
	assign do_pop   = accept && is_pop && (count_q != '0);
	assign ctrl.push = do_push;
	assign ctrl.pop  = do_pop;

	// Row of slot cells, front at index 0
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   prev_k;

		assign cell_occ[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign prev_e = new_entry;
			assign prev_k = 1'b0;
		end else begin : g_mid
			assign prev_e = cell_entry[i-1];
			assign prev_k = cell_keep[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_e = cell_entry[i];
		end else begin : g_inner
			assign next_e = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.new_entry  (new_entry),
			.prev_entry (prev_e),
			.prev_keep  (prev_k),
			.next_entry (next_e),
			.occ        (cell_occ[i]),
			.entry      (cell_entry[i]),
			.entry_nxt  (cell_nxt[i]),
			.keep       (cell_keep[i])
		);
	end

	// New entry lands at the tail when every occupied slot keeps its place
	assign at_end = &(cell_keep | ~cell_occ);

	always_comb begin
		count_nxt = count_q;
		back_nxt  = back_q;
		if (do_push) begin
			count_nxt = count_q + CNT_W'(1);
			if (at_end)
				back_nxt = new_entry.value;
		end else if (do_pop) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_comb begin
		status = ST_OK;
		if (accept && is_pop && !do_pop)
			status = ST_EMPTY;
		else if (accept && !is_pop && !do_push)
			status = ST_FULL;
	end

	// Advance occupancy and tail tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		back_q <= back_nxt;
	end

	// Result register: load on input transfer, drop on output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_popped_q <= do_pop ? cell_entry[0].value : '0;
			out_front_q  <= (count_nxt == '0) ? INT_MIN : cell_nxt[0].value;
			out_back_q   <= (count_nxt == '0) ? INT_MIN : back_nxt;
			out_count_q  <= 5'(count_nxt);
			out_status_q <= status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_status_q, out_count_q, out_back_q,
	                        out_front_q, out_popped_q};

endmodule

[hdl/spq_checker.sv]
module spq_checker
	import spq_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [103:0] m_axis_tdata
);

	// A stalled result holds its data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// An input transfer yields a result in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("missing result after input transfer");

	// Count never exceeds capacity
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[100:96] <= 5'(CAPACITY))
		else $error("entry count above capacity");

	// Empty queue reports the minimum value at both ends
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[100:96] == '0 |->
		m_axis_tdata[63:32] == INT_MIN && m_axis_tdata[95:64] == INT_MIN)
		else $error("empty queue shows a value");

	// A pop on empty leaves nothing popped and nothing stored
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[102:101] == ST_EMPTY |->
		m_axis_tdata[31:0] == '0 && m_axis_tdata[100:96] == '0)
		else $error("pop on empty returned data");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

[tb/sorted_priority_queue_tb.sv]
module sorted_priority_queue_tb
	import spq_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 333;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic [VALUE_BITS-1:0] popped;
		logic [VALUE_BITS-1:0] front;
		logic [VALUE_BITS-1:0] back;
		logic [CNT_W-1:0]      count;
		logic [1:0]            status;
	} queue_result_t;

	typedef struct packed {
		logic                  act;
		logic [VALUE_BITS-1:0] val;
		logic [PRIO_BITS-1:0]  prio;
		logic                  pinned;
		queue_result_t         want;
	} queue_op_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [47:0]  s_axis_tdata = '0;   // item_value[31:0], item_priority[47:32]
	logic [0:0]   s_axis_tuser = '0;   // action[0]
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;        // popped_value[31:0], front_value[63:32],
	                                   // back_value[95:64], entry_count[100:96],
	                                   // status[102:101], zero pad[103]

	// Fixed expectation that rides along with the item on the bus
	logic          stim_pinned = 1'b0;
	queue_result_t stim_want = '0;

	int            send_idle_pct = 7;
	int            recv_idle_pct = 69;
	logic          pressure_go = 1'b0;
	logic          hold_off = 1'b0;
	int            cycle_count = 0;
	int            mismatch_count = 0;
	int            results_checked = 0;
	int            push_total = 0;
	int            pop_total = 0;
	int            full_drops = 0;
	int            empty_pops = 0;

	// Shadow copy of the sorted slots, front first
	logic [VALUE_BITS-1:0] shadow_values [CAPACITY];
	logic [PRIO_BITS-1:0]  shadow_prios  [CAPACITY];
	int                    shadow_count = 0;
	queue_result_t         pending_results[$];

	sorted_priority_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Apply one push or pop to the shadow queue and build the result it gives
	task automatic apply_queue_op(input logic act, input logic [VALUE_BITS-1:0] val,
			input logic [PRIO_BITS-1:0] prio, output queue_result_t res);
		int pos;
		int i;
		res = '0;
		res.status = ST_OK;
		if (act == ACT_PUSH) begin
			if (shadow_count >= CAPACITY) begin
				res.status = ST_FULL;
			end else begin
				// insert behind every entry of equal or higher priority
				pos = 0;
				while (pos < shadow_count && shadow_prios[pos] >= prio)
					pos++;
				for (i = shadow_count; i > pos; i--) begin
					shadow_values[i] = shadow_values[i-1];
					shadow_prios[i]  = shadow_prios[i-1];
				end
				shadow_values[pos] = val;
				shadow_prios[pos]  = prio;
				shadow_count++;
			end
		end else begin
			if (shadow_count == 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.popped = shadow_values[0];
				for (i = 1; i < shadow_count; i++) begin
					shadow_values[i-1] = shadow_values[i];
					shadow_prios[i-1]  = shadow_prios[i];
				end
				shadow_count--;
			end
		end
		if (shadow_count == 0) begin
			res.front = INT_MIN;
			res.back  = INT_MIN;
		end else begin
			res.front = shadow_values[0];
			res.back  = shadow_values[shadow_count-1];
		end
		res.count = CNT_W'(shadow_count);
	endtask

	task automatic check_field(input string name, input logic [VALUE_BITS-1:0] want,
			input logic [VALUE_BITS-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Predict on every input transfer, compare on every output transfer
	always @(posedge clk) begin : scoreboard
		queue_result_t calc;
		queue_result_t seen;
		queue_result_t want;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			apply_queue_op(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[47:32], calc);
			pending_results.push_back(stim_pinned ? stim_want : calc);
			if (s_axis_tuser[0] == ACT_PUSH)
				push_total++;
			else
				pop_total++;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.popped = m_axis_tdata[31:0];
			seen.front  = m_axis_tdata[63:32];
			seen.back   = m_axis_tdata[95:64];
			seen.count  = m_axis_tdata[100:96];
			seen.status = m_axis_tdata[102:101];
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, seen);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("popped_value", want.popped, seen.popped);
				check_field("front_value", want.front, seen.front);
				check_field("back_value", want.back, seen.back);
				check_field("entry_count", 32'(want.count), 32'(seen.count));
				check_field("status", 32'(want.status), 32'(seen.status));
				results_checked++;
				if (want.status == ST_FULL)
					full_drops++;
				if (want.status == ST_EMPTY)
					empty_pops++;
			end
		end
	end

	// Receiver side: random stalls, forced low during the hold-off
	always @(posedge clk) begin
		m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Hold off the receiver for a long stretch so the block backs up
	initial begin : receiver_hold
		int held;
		held = 0;
		do @(posedge clk); while (!pressure_go);
		hold_off <= 1'b1;
		while (held < HOLD_CYCLES) begin
			@(posedge clk);
			held++;
		end
		hold_off <= 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles, %0d results outstanding", $time,
				CYCLE_LIMIT, pending_results.size());
			$display("FAILURE");
			$finish;
		end
	end

	// Offer one item and hold it until the transfer
	task automatic send_item(input queue_op_t op);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op.act;
		s_axis_tdata  <= {op.prio, op.val};
		stim_pinned   <= op.pinned;
		stim_want     <= op.want;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	function automatic queue_op_t make_op(input logic act, input logic [VALUE_BITS-1:0] val,
			input logic [PRIO_BITS-1:0] prio);
		queue_op_t op;
		op = '0;
		op.act  = act;
		op.val  = val;
		op.prio = prio;
		return op;
	endfunction

	function automatic queue_op_t pin_result(input queue_op_t op,
			input logic [VALUE_BITS-1:0] popped, input logic [VALUE_BITS-1:0] front,
			input logic [VALUE_BITS-1:0] back, input int count, input logic [1:0] status);
		op.pinned      = 1'b1;
		op.want.popped = popped;
		op.want.front  = front;
		op.want.back   = back;
		op.want.count  = CNT_W'(count);
		op.want.status = status;
		return op;
	endfunction

	function automatic queue_op_t random_op(input int push_pct);
		queue_op_t op;
		logic [VALUE_BITS-1:0] val;
		logic [PRIO_BITS-1:0]  prio;
		int pick;
		val = $urandom;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			val = INT_MIN;
		else if (pick == 1)
			val = 32'h7FFF_FFFF;
		else if (pick == 2)
			val = '1;
		else if (pick == 3)
			val = '0;
		// crowd priorities into a few values so ties are common
		pick = $urandom_range(0, 9);
		if (pick < 4)
			prio = PRIO_BITS'($urandom_range(0, 3));
		else if (pick == 4)
			prio = '1;
		else if (pick == 5)
			prio = '0;
		else
			prio = PRIO_BITS'($urandom_range(0, 65535));
		op = make_op(($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP, val, prio);
		return op;
	endfunction

	initial begin : stimulus
		queue_op_t directed[$];
		int push_mix [4];
		int push_pct;
		int phase;
		int n;

		push_mix = '{20, 50, 80, 95};
		push_pct = 50;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: empty pop, extreme values and priorities, ties, fill, overflow
		directed.push_back(pin_result(make_op(ACT_POP, '0, '0),
			'0, INT_MIN, INT_MIN, 0, ST_EMPTY));
		directed.push_back(pin_result(make_op(ACT_PUSH, INT_MIN, '0),
			'0, INT_MIN, INT_MIN, 1, ST_OK));
		directed.push_back(pin_result(make_op(ACT_PUSH, 32'h7FFF_FFFF, '1),
			'0, 32'h7FFF_FFFF, INT_MIN, 2, ST_OK));
		directed.push_back(make_op(ACT_PUSH, 32'd1, '1));
		directed.push_back(make_op(ACT_PUSH, '1, '0));
		directed.push_back(make_op(ACT_POP, 32'hDEAD_BEEF, 16'h1234));
		for (n = 0; n < 13; n++)
			directed.push_back(make_op(ACT_PUSH, 32'h1000_0000 + n, PRIO_BITS'(n % 4 * 21845)));
		directed.push_back(make_op(ACT_PUSH, 32'h5555_5555, 16'hAAAA));
		directed.push_back(make_op(ACT_POP, '0, '0));
		directed.push_back(make_op(ACT_POP, '0, '0));
		foreach (directed[i])
			send_item(directed[i]);

		// Random traffic under three idle patterns
		for (phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				send_idle_pct = 69;
				recv_idle_pct = 7;
			end else if (phase == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				pressure_go <= 1'b1;
			end
			for (n = 0; n < RANDOM_ITEMS; n++) begin
				// swing the push rate so the queue runs both full and empty
				if (n % 40 == 0)
					push_pct = push_mix[$urandom_range(0, 3)];
				send_item(random_op(push_pct));
			end
		end
		s_axis_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results from %0d pushes and %0d pops", results_checked,
			push_total, pop_total);
		$display("Pushes dropped on a full queue: %0d, pops on an empty queue: %0d",
			full_drops, empty_pops);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[sorted_priority_queue.f]
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
hdl/spq_checker.sv
tb/sorted_priority_queue_tb.sv
